[hdl/rsbs_pkg.sv]
package rsbs_pkg;

    // Element sizing
    localparam int MaxValueBytes = 16;
    localparam int PosW          = $clog2(MaxValueBytes);
    localparam int HeldW         = PosW + 1;
    localparam int CountW        = 32;

    // Element queue between front and back (depth must be a power of two)
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // Record layouts
    localparam logic [1:0] KindScalar = 2'd0;
    localparam logic [1:0] KindVector = 2'd1;
    localparam logic [1:0] KindSparse = 2'd2;

    // Parser phases
    localparam logic [1:0] PhHead  = 2'd0;
    localparam logic [1:0] PhIndex = 2'd1;
    localparam logic [1:0] PhValue = 2'd2;

    // Register select, taken from paddr[2]
    localparam logic RegContainerKind = 1'b0;
    localparam logic RegValueBytes    = 1'b1;

    localparam logic [4:0] ValueBytesReset = 5'd4;
    localparam logic [4:0] CountBytes      = 5'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_block;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       format_error;
    } out_t;

    typedef struct packed {
        logic [1:0] container_kind;
        logic [4:0] value_bytes;
    } cfg_t;

    typedef logic [MaxValueBytes-1:0][7:0] elem_bytes_t;

    typedef struct packed {
        elem_bytes_t      bytes;
        logic [HeldW-1:0] held;
        logic             reversed;
        logic             last;
        logic             error;
    } elem_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[hdl/rsbs_front.sv]
module rsbs_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  rsbs_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  rsbs_pkg::in_t    in_data,
    input  rsbs_pkg::q_stat_t q_stat,
    output logic             push,
    output rsbs_pkg::elem_t  push_elem
);

    logic [1:0]                      phase_reg, phase_next;
    logic [rsbs_pkg::PosW-1:0]       pos_reg, pos_next;
    logic [rsbs_pkg::CountW-1:0]     count_reg, count_next;
    rsbs_pkg::elem_bytes_t           buf_reg, buf_next;

    logic                            accept;
    logic                            will_push;
    logic                            size_ok;
    logic                            cfg_err;
    logic [4:0]                      need;
    logic [rsbs_pkg::HeldW-1:0]      held;
    logic [rsbs_pkg::CountW-1:0]     count_word;
    logic [rsbs_pkg::CountW-1:0]     head_count;

    // Hold the byte only when it would hand an element to a full queue
    assign will_push = cfg_err || (held >= rsbs_pkg::HeldW'(need)) ||
                       in_data.last_of_block;
    assign in_stall  = q_stat.full && will_push;
    assign accept    = in_valid && !in_stall;

    assign size_ok = (cfg.value_bytes <= 5'(rsbs_pkg::MaxValueBytes)) &&
                     (cfg.value_bytes == 5'd1 || cfg.value_bytes == 5'd2 ||
                      cfg.value_bytes == 5'd4 || cfg.value_bytes == 5'd8 ||
                      cfg.value_bytes == 5'd16);
    assign cfg_err = (cfg.container_kind > rsbs_pkg::KindSparse) || !size_ok ||
                     (cfg.container_kind == rsbs_pkg::KindScalar &&
                      cfg.value_bytes == 5'd1);

    always_comb
    begin
        unique case (phase_reg)
            rsbs_pkg::PhIndex: need = rsbs_pkg::CountBytes;
            rsbs_pkg::PhValue: need = cfg.value_bytes;
            default:           need = (cfg.container_kind == rsbs_pkg::KindScalar) ?
                                      cfg.value_bytes : rsbs_pkg::CountBytes;
        endcase
    end

    always_comb
    begin
        buf_next          = buf_reg;
        buf_next[pos_reg] = in_data.data_byte;
    end

    assign held       = rsbs_pkg::HeldW'(pos_reg) + rsbs_pkg::HeldW'(1);
    // Counts arrive big-endian
    assign count_word = {buf_next[0], buf_next[1], buf_next[2], buf_next[3]};
    assign head_count = (held == rsbs_pkg::HeldW'(4)) ? count_word : '0;

    always_comb
    begin
        phase_next         = phase_reg;
        pos_next           = pos_reg;
        count_next         = count_reg;
        push               = 1'b0;
        push_elem.bytes    = buf_next;
        push_elem.held     = held;
        push_elem.reversed = 1'b1;
        push_elem.last     = in_data.last_of_block;
        push_elem.error    = 1'b0;

        if (accept)
        begin
            if (cfg_err)
            begin
                // pass the byte through flagged, and restart parsing
                push               = 1'b1;
                push_elem.bytes    = buf_reg;
                push_elem.bytes[0] = in_data.data_byte;
                push_elem.held     = rsbs_pkg::HeldW'(1);
                push_elem.reversed = 1'b0;
                push_elem.error    = 1'b1;
                phase_next         = rsbs_pkg::PhHead;
                pos_next           = '0;
                count_next         = '0;
            end
            else if (held < rsbs_pkg::HeldW'(need))
            begin
                if (in_data.last_of_block)
                begin
                    // block ends mid-element: flush in arrival order
                    push               = 1'b1;
                    push_elem.reversed = 1'b0;
                    phase_next         = rsbs_pkg::PhHead;
                    pos_next           = '0;
                    count_next         = '0;
                end
                else
                begin
                    pos_next = pos_reg + rsbs_pkg::PosW'(1);
                end
            end
            else
            begin
                push     = 1'b1;
                pos_next = '0;
                unique case (phase_reg)
                    rsbs_pkg::PhIndex:
                    begin
                        phase_next = rsbs_pkg::PhValue;
                    end
                    rsbs_pkg::PhValue:
                    begin
                        if (count_reg <= rsbs_pkg::CountW'(1))
                        begin
                            count_next = '0;
                            phase_next = rsbs_pkg::PhHead;
                        end
                        else
                        begin
                            count_next = count_reg - rsbs_pkg::CountW'(1);
                            phase_next = (cfg.container_kind == rsbs_pkg::KindSparse) ?
                                         rsbs_pkg::PhIndex : rsbs_pkg::PhValue;
                        end
                    end
                    default:
                    begin
                        if (cfg.container_kind != rsbs_pkg::KindScalar)
                        begin
                            count_next = head_count;
                            if (head_count == '0)
                                phase_next = rsbs_pkg::PhHead;
                            else
                                phase_next = (cfg.container_kind == rsbs_pkg::KindSparse) ?
                                             rsbs_pkg::PhIndex : rsbs_pkg::PhValue;
                        end
                        else
                        begin
                            phase_next = rsbs_pkg::PhHead;
                        end
                    end
                endcase
                if (in_data.last_of_block)
                begin
                    phase_next = rsbs_pkg::PhHead;
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rsbs_pkg::PhHead;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cfg_err)
            buf_reg <= buf_next;
    end

endmodule

[hdl/rsbs_queue.sv]
module rsbs_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rsbs_pkg::elem_t   push_elem,
    input  logic              pop,
    output rsbs_pkg::elem_t   head,
    output rsbs_pkg::q_stat_t q_stat
);

    rsbs_pkg::elem_t                 mem [rsbs_pkg::QueueDepth];
    logic [rsbs_pkg::QPtrW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [rsbs_pkg::QCntW-1:0]      cnt_reg, cnt_next;

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == rsbs_pkg::QCntW'(rsbs_pkg::QueueDepth));
    assign q_stat.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + rsbs_pkg::QCntW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - rsbs_pkg::QCntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + rsbs_pkg::QPtrW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + rsbs_pkg::QPtrW'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_elem;
    end

endmodule

[hdl/rsbs_back.sv]
module rsbs_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  rsbs_pkg::elem_t   head,
    input  rsbs_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output rsbs_pkg::out_t    out_data
);

    logic [rsbs_pkg::PosW-1:0] idx_reg;
    logic [rsbs_pkg::PosW-1:0] last_idx;
    logic [rsbs_pkg::PosW-1:0] sel;
    logic                      final_byte;
    logic                      load;
    logic                      out_valid_reg;
    rsbs_pkg::out_t            out_data_reg;

    assign last_idx   = rsbs_pkg::PosW'(head.held - rsbs_pkg::HeldW'(1));
    assign sel        = head.reversed ? (last_idx - idx_reg) : idx_reg;
    assign final_byte = (idx_reg == last_idx);
    assign load       = !q_stat.empty && (!out_valid_reg || !out_stall);
    assign pop        = load && final_byte;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (pop)
                idx_reg <= '0;
            else if (load)
                idx_reg <= idx_reg + rsbs_pkg::PosW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.out_byte     <= head.bytes[sel];
            out_data_reg.out_last     <= head.last && final_byte;
            out_data_reg.format_error <= head.error;
        end
    end

endmodule

[hdl/record_stream_byte_swapper.sv]
// Record stream byte swapper.
// Input channel (in_valid / in_stall / in_data) takes one byte of a grid data
// block per transaction, with last_of_block on its final byte. The block
// gathers the bytes of each element (counts, indices, values, as the layout
// in container_kind and value_bytes dictates) and, once an element is whole,
// emits it on the output channel in reversed byte order, one byte per
// transaction. A block ending inside an element flushes its bytes unreversed.
// An unsupported configuration passes each byte through with format_error set.
// Throughput: one byte per cycle on each side while out_stall is low and the
// queue has room. An element enters the queue when its final input byte is
// accepted; its bytes then leave through the single-byte output register of
// the back end, one per cycle while out_stall is low.
// A two-entry element queue parts the parser from the serialiser; the input
// stalls only while that queue is full and the offered byte would complete an
// element, end the block or pass through flagged, so a stalled receiver backs
// up into the queue and then into the input channel without losing a transaction.
// Reset clears the parser to expect a count or scalar value, empties the
// queue and drops any pending output; registers return to scalar layout with
// four-byte values. Configure over APB only while the block is idle.
module record_stream_byte_swapper
(
    input  logic           clk,
    input  logic           rst_n,
    // APB configuration port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    // input channel
    input  logic           in_valid,
    output logic           in_stall,
    input  rsbs_pkg::in_t  in_data,
    // output channel
    output logic           out_valid,
    input  logic           out_stall,
    output rsbs_pkg::out_t out_data
);

    logic [1:0]        kind_reg;
    logic [4:0]        vb_reg;
    logic              cfg_wr;
    rsbs_pkg::cfg_t    cfg;

    logic              push;
    logic              pop;
    rsbs_pkg::elem_t   push_elem;
    rsbs_pkg::elem_t   head;
    rsbs_pkg::q_stat_t q_stat;

    // Register file: word-aligned, low address bits ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == rsbs_pkg::RegValueBytes)
            prdata = {27'd0, vb_reg};
        else
            prdata = {30'd0, kind_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= rsbs_pkg::KindScalar;
            vb_reg   <= rsbs_pkg::ValueBytesReset;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == rsbs_pkg::RegContainerKind)
                kind_reg <= pwdata[1:0];
            else
                vb_reg <= pwdata[4:0];
        end
    end

    assign cfg.container_kind = kind_reg;
    assign cfg.value_bytes    = vb_reg;

    // Front end: gather and classify bytes, hand whole elements to the queue
    rsbs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_elem (push_elem)
    );

    // Hold completed elements until the back end drains them
    rsbs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_elem (push_elem),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // Back end: serialise each element one byte per transaction
    rsbs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("element queue overflow");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("element queue underflow");

    // A waiting element reaches an empty output register on the next edge
    a_output_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_stat.empty && !out_valid) |=> out_valid)
        else $error("output register left empty while an element waits");

endmodule

[sim/rsbs_checker.sv]
`timescale 1ns / 100ps
module rsbs_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic           pready,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic           in_valid,
    input  logic           in_stall,
    input  rsbs_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  rsbs_pkg::out_t out_data,
    output int             fails,
    output int             pending
);

    rsbs_pkg::cfg_t layout;
    logic [1:0]     phase;
    logic [4:0]     pos;
    logic [7:0]     gathered [rsbs_pkg::MaxValueBytes];
    logic [31:0]    left_count;
    rsbs_pkg::out_t due_bytes [$];
    int             mismatches = 0;

    function automatic logic layout_ok();
        logic size_legal;
        case (layout.value_bytes)
            5'd1, 5'd2, 5'd4, 5'd8, 5'd16:
                size_legal = (layout.value_bytes <= rsbs_pkg::MaxValueBytes);
            default:
                size_legal = 1'b0;
        endcase
        return size_legal && layout.container_kind <= rsbs_pkg::KindSparse &&
               !(layout.container_kind == rsbs_pkg::KindScalar &&
                 layout.value_bytes == 5'd1);
    endfunction

    task automatic restart_parse();
        phase      = rsbs_pkg::PhHead;
        pos        = '0;
        left_count = '0;
    endtask

    task automatic expect_byte(input logic [7:0] b, input logic l, input logic e);
        rsbs_pkg::out_t o;
        o.out_byte     = b;
        o.out_last     = l;
        o.format_error = e;
        due_bytes.push_back(o);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Gather one source byte; queue the swapped bytes of an element it completes, a cut one as is, or a flagged byte.
    task automatic swap_in(input rsbs_pkg::in_t item);
        int need;
        int held;
        int i;
        logic [31:0] c;
        if (!layout_ok())
        begin
            restart_parse();
            expect_byte(item.data_byte, item.last_of_block, 1'b1);
            return;
        end
        if (phase == rsbs_pkg::PhIndex)
            need = rsbs_pkg::CountBytes;
        else if (phase == rsbs_pkg::PhValue || layout.container_kind == rsbs_pkg::KindScalar)
            need = layout.value_bytes;
        else
            need = rsbs_pkg::CountBytes;
        if (pos >= rsbs_pkg::MaxValueBytes)
            pos = 5'(rsbs_pkg::MaxValueBytes - 1);
        gathered[pos] = item.data_byte;
        held = pos + 1;
        if (held < need)
        begin
            if (item.last_of_block)
            begin
                for (i = 0; i < held; i++)
                    expect_byte(gathered[i], i == held - 1, 1'b0);
                restart_parse();
            end
            else
                pos = 5'(held);
            return;
        end
        for (i = 0; i < held; i++)
            expect_byte(gathered[held - 1 - i], item.last_of_block && i == held - 1, 1'b0);
        pos = '0;
        if (phase == rsbs_pkg::PhIndex)
            phase = rsbs_pkg::PhValue;
        else if (phase == rsbs_pkg::PhValue)
        begin
            if (left_count <= 1)
            begin
                left_count = '0;
                phase = rsbs_pkg::PhHead;
            end
            else
            begin
                left_count = left_count - 32'd1;
                phase = (layout.container_kind == rsbs_pkg::KindSparse) ?
                        rsbs_pkg::PhIndex : rsbs_pkg::PhValue;
            end
        end
        else if (layout.container_kind != rsbs_pkg::KindScalar)
        begin
            c = {gathered[0], gathered[1], gathered[2], gathered[3]};
            if (held != 4)
                c = '0;
            left_count = c;
            if (c == 0)
                phase = rsbs_pkg::PhHead;
            else
                phase = (layout.container_kind == rsbs_pkg::KindSparse) ?
                        rsbs_pkg::PhIndex : rsbs_pkg::PhValue;
        end
        else
            phase = rsbs_pkg::PhHead;
        if (item.last_of_block)
            restart_parse();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsbs_pkg::out_t want;
        if (!rst_n)
        begin
            layout.container_kind = rsbs_pkg::KindScalar;
            layout.value_bytes    = rsbs_pkg::ValueBytesReset;
            restart_parse();
            due_bytes.delete();
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_bytes.size() == 0)
                    report_mismatch("output byte with nothing due", out_data, 0);
                else
                begin
                    want = due_bytes.pop_front();
                    if (out_data.out_byte != want.out_byte)
                        report_mismatch("out_byte", out_data.out_byte, want.out_byte);
                    if (out_data.out_last != want.out_last)
                        report_mismatch("out_last", out_data.out_last, want.out_last);
                    if (out_data.format_error != want.format_error)
                        report_mismatch("format_error", out_data.format_error,
                                        want.format_error);
                end
            end
            if (in_valid && !in_stall)
                swap_in(in_data);
            // A register write takes effect for transactions after this edge
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == rsbs_pkg::RegContainerKind)
                    layout.container_kind = pwdata[1:0];
                else
                    layout.value_bytes = pwdata[4:0];
            end
            fails   <= mismatches;
            pending <= due_bytes.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
module tb;

    // Register addresses: the select bit sits at paddr[2]
    localparam logic [2:0] AddrKind = {rsbs_pkg::RegContainerKind, 2'b00};
    localparam logic [2:0] AddrSize = {rsbs_pkg::RegValueBytes, 2'b00};
    // The one container code the block must reject
    localparam logic [1:0] KindUnused = 2'd3;

    logic           clk;
    logic           rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;
    logic           in_valid;
    logic           in_stall;
    rsbs_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    rsbs_pkg::out_t out_data;
    int             fails;
    int             pending;

    // Set while both sides must run flat out with no idle cycles
    logic        steady = 1'b0;
    logic [7:0]  blk [$];
    int          rand_items = 0;

    record_stream_byte_swapper dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    rsbs_checker swap_watch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver back-pressure: stall at random with odds of 23 in 100, never while steady
    always @(negedge clk)
        out_stall <= (!steady && rst_n) ? ($urandom_range(0, 99) < 23) : 1'b0;

    // Offer one byte at a falling edge, idling at random first; hold it until
    // the transaction is taken at a rising edge.
    task automatic push_byte(input logic [7:0] b, input logic l);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid              <= 1'b1;
        in_data.data_byte     <= b;
        in_data.last_of_block <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid, then hold off until every due byte has come out and the
    // parser has had time to settle; config writes only happen from here.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_layout(input logic [1:0] kind, input logic [4:0] size);
        write_reg(AddrKind, {30'd0, kind});
        write_reg(AddrSize, {27'd0, size});
    endtask

    // Draw a layout; the first twelve entries are legal, the rest are rejected.
    task automatic pick_layout(output logic [1:0] kind, output logic [4:0] size,
                               output logic legal);
        int idx;
        idx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 11) : $urandom_range(12, 17);
        case (idx)
            0:       begin kind = rsbs_pkg::KindScalar; size = 5'd2;  end
            1:       begin kind = rsbs_pkg::KindScalar; size = 5'd4;  end
            2:       begin kind = rsbs_pkg::KindScalar; size = 5'd8;  end
            3:       begin kind = rsbs_pkg::KindScalar; size = 5'd16; end
            4:       begin kind = rsbs_pkg::KindVector; size = 5'd1;  end
            5:       begin kind = rsbs_pkg::KindVector; size = 5'd2;  end
            6:       begin kind = rsbs_pkg::KindVector; size = 5'd4;  end
            7:       begin kind = rsbs_pkg::KindVector; size = 5'd16; end
            8:       begin kind = rsbs_pkg::KindSparse; size = 5'd1;  end
            9:       begin kind = rsbs_pkg::KindSparse; size = 5'd2;  end
            10:      begin kind = rsbs_pkg::KindSparse; size = 5'd8;  end
            11:      begin kind = rsbs_pkg::KindSparse; size = 5'd16; end
            12:      begin kind = rsbs_pkg::KindScalar; size = 5'd1;  end
            13:      begin kind = KindUnused;           size = 5'd4;  end
            14:      begin kind = rsbs_pkg::KindVector; size = 5'd3;  end
            15:      begin kind = rsbs_pkg::KindSparse; size = 5'd0;  end
            16:      begin kind = rsbs_pkg::KindVector; size = 5'd31; end
            default: begin kind = rsbs_pkg::KindScalar; size = 5'd12; end
        endcase
        legal = (idx < 12);
    endtask

    // Build one block: mostly well-formed records with random content, some
    // cut short, some plain noise. Huge counts end the block inside the record.
    task automatic build_block(input logic [1:0] kind, input logic [4:0] size,
                               input logic legal);
        int roll;
        int recs;
        int r;
        int n;
        logic [31:0] count;
        logic open_ended;
        blk.delete();
        roll = $urandom_range(0, 99);
        if (!legal || roll < 10)
        begin
            n = $urandom_range(1, legal ? 10 : 6);
            repeat (n) blk.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (kind == rsbs_pkg::KindScalar)
        begin
            n = $urandom_range(1, (24 / size > 1) ? 24 / size : 1);
            repeat (n * size) blk.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            recs = $urandom_range(1, 2);
            open_ended = 1'b0;
            for (r = 0; r < recs && !open_ended; r++)
            begin
                if ($urandom_range(0, 99) < 15)
                    count = $urandom;
                else
                    count = $urandom_range(0, (size == 5'd16) ? 2 : 3);
                blk.push_back(count[31:24]);
                blk.push_back(count[23:16]);
                blk.push_back(count[15:8]);
                blk.push_back(count[7:0]);
                if (count > 3)
                begin
                    repeat ($urandom_range(1, 6)) blk.push_back(8'($urandom_range(0, 255)));
                    open_ended = 1'b1;
                end
                else
                    repeat (count)
                    begin
                        if (kind == rsbs_pkg::KindSparse)
                            repeat (4) blk.push_back(8'($urandom_range(0, 255)));
                        repeat (size) blk.push_back(8'($urandom_range(0, 255)));
                    end
            end
        end
        // Truncate some blocks so they end inside an element
        if (roll < 25 && blk.size() > 1)
        begin
            n = $urandom_range(1, blk.size() - 1);
            while (blk.size() > n)
                void'(blk.pop_back());
        end
    endtask

    task automatic send_block();
        int i;
        for (i = 0; i < blk.size(); i++)
        begin
            push_byte(blk[i], i == blk.size() - 1);
            rand_items++;
        end
    endtask

    initial
    begin
        logic [1:0] kind;
        logic [4:0] size;
        logic       legal;
        int         nb;

        // Known values on every input from time zero
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset layout is scalar four-byte values: extremes of the byte, one
        // whole value, then a block ending inside the next value
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7E, 1'b1);

        // Sparse one-byte values with a count of one; switch to vector layout
        // while the index is due, which must still take four bytes
        set_layout(rsbs_pkg::KindSparse, 5'd1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        write_reg(AddrKind, {30'd0, rsbs_pkg::KindVector});
        push_byte(8'h0A, 1'b0);
        push_byte(8'h0B, 1'b0);
        push_byte(8'h0C, 1'b0);
        push_byte(8'h0D, 1'b0);
        push_byte(8'h5C, 1'b1);

        // Vector eight-byte values: a zero count, then a count of one whose
        // value size drops to two after three bytes, so the fourth completes it
        set_layout(rsbs_pkg::KindVector, 5'd8);
        repeat (4) push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b0);
        write_reg(AddrSize, 32'd2);
        push_byte(8'h44, 1'b1);

        // Rejected layouts pass bytes through flagged
        set_layout(rsbs_pkg::KindScalar, 5'd1);
        push_byte(8'hAA, 1'b0);
        set_layout(KindUnused, 5'd16);
        push_byte(8'h55, 1'b1);

        // Random layouts and blocks; each layout change drains the block first,
        // which also gives the pause with nothing left outstanding
        while (rand_items < 240)
        begin
            pick_layout(kind, size, legal);
            set_layout(kind, size);
            steady = (rand_items >= 100 && rand_items < 180);
            nb = $urandom_range(1, 3);
            repeat (nb)
            begin
                build_block(kind, size, legal);
                send_block();
            end
        end
        steady = 1'b0;

        // Let the tail drain, then allow the pipeline latency to pass
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
hdl/rsbs_pkg.sv
hdl/rsbs_front.sv
hdl/rsbs_queue.sv
hdl/rsbs_back.sv
hdl/record_stream_byte_swapper.sv
sim/rsbs_checker.sv
sim/tb.sv
